// ===== hdl/satp_pkg.sv =====
`default_nettype none

package satp_pkg;

    localparam int C_MAX_SPRITES = 128;
    localparam int C_ENTRY_COUNT = 128;
    localparam int C_HIGH_BYTES  = 32;
    localparam int C_TABLE_BYTES = 544;

    localparam int C_ENTRY_AW = $clog2(C_ENTRY_COUNT);
    localparam int C_HIGH_AW  = $clog2(C_HIGH_BYTES);

    localparam logic [7:0] C_HIDDEN_Y = 8'd224;

    localparam logic signed [15:0] C_POS_MIN = -16'sd64;
    localparam logic signed [15:0] C_X_LIMIT = 16'sd256;
    localparam logic signed [15:0] C_Y_LIMIT = 16'sd224;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FLUSH = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_ENTRY = 2'd1,
        RD_HIGH  = 2'd2
    } t_rd_kind;

    typedef struct packed {
        logic                  en;
        logic [C_ENTRY_AW-1:0] addr;
        logic [31:0]           data;
    } t_entry_wr;

    typedef struct packed {
        logic                 en;
        logic [C_HIGH_AW-1:0] addr;
        logic [7:0]           data;
    } t_high_wr;

    typedef struct packed {
        logic                 en;
        logic [C_HIGH_AW-1:0] addr;
    } t_high_rd;

endpackage

`default_nettype wire

// ===== hdl/sprite_attribute_table_packer_top.sv =====
// result path: the synchronous table read registers the byte, and the result
// register then holds it for the output
// requests: the next request is held back while one is pending and while a presented
// result is stalled, so a new one is taken only once the last has reached the result register
// reset: synchronous, active low; clears counters, the high accumulator and the
// entry and high table valid bits at once, no clearing pass
`default_nettype none

module sprite_attribute_table_packer_top import satp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [15:0] i_sprite_x,
    input  wire logic signed [15:0] i_sprite_y,
    input  wire logic [8:0]         i_tile_id,
    input  wire logic [7:0]         i_attr_flags,
    input  wire logic [9:0]         i_read_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [7:0]              o_read_data,
    output logic                    o_sprite_kept,
    output logic                    o_table_full
);

    logic                     r_pend;
    logic                     r_out_valid;
    logic [7:0]               r_out_data;
    logic                     r_out_kept;
    logic                     r_out_full;

    logic [7:0]               r_count;
    logic [7:0]               r_high_acc;
    logic [1:0]               r_high_slot;
    logic [5:0]               r_high_index;
    logic [C_ENTRY_COUNT-1:0] r_written;

    logic                     r_res_kept;
    logic                     r_res_full;
    t_rd_kind                 r_rd_kind;
    logic [1:0]               r_rd_byte;
    logic                     r_rd_written;

    logic                     w_accept;
    t_op                      w_op;
    logic                     w_in_range;
    logic                     w_full;
    logic                     w_keep;
    logic [1:0]               w_hib;
    logic [7:0]               w_acc_next;
    logic                     w_high_ok;
    t_rd_kind                 w_rd_kind;
    t_entry_wr                w_entry_wr;
    t_high_wr                 w_high_wr;
    t_high_rd                 w_high_rd;
    logic                     w_entry_rd_en;
    logic [31:0]              w_entry_data;
    logic [7:0]               w_high_data;
    logic [7:0]               w_entry_byte;
    logic [7:0]               w_res_data;

    // one request in flight; the next waits until the result register is free
    assign o_in_stall = r_pend || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_op       = t_op'(i_op);

    assign w_in_range = (i_sprite_x > C_POS_MIN) && (i_sprite_x < C_X_LIMIT) &&
                        (i_sprite_y > C_POS_MIN) && (i_sprite_y < C_Y_LIMIT);
    assign w_full     = w_in_range && (r_count >= 8'(C_MAX_SPRITES));
    assign w_keep     = w_in_range && !w_full;
    assign w_hib      = {i_attr_flags[0], i_sprite_x[8]};
    assign w_acc_next = r_high_acc | ({6'd0, w_hib} << {r_high_slot, 1'b0});
    assign w_high_ok  = r_high_index < 6'(C_HIGH_BYTES);

    always_comb begin
        if (i_read_index >= 10'(C_TABLE_BYTES)) begin
            w_rd_kind = RD_NONE;
        end else if (i_read_index[9]) begin
            w_rd_kind = RD_HIGH;
        end else begin
            w_rd_kind = RD_ENTRY;
        end
    end

    always_comb begin
        w_entry_wr.en   = w_accept && (w_op == OP_ADD) && w_keep;
        w_entry_wr.addr = r_count[C_ENTRY_AW-1:0];
        w_entry_wr.data = {i_attr_flags[7:1], i_tile_id[8], i_tile_id[7:0],
                           i_sprite_y[7:0], i_sprite_x[7:0]};

        w_high_wr.en    = 1'b0;
        w_high_wr.addr  = r_high_index[C_HIGH_AW-1:0];
        w_high_wr.data  = r_high_acc;
        case (w_op)
            OP_ADD: begin
                w_high_wr.en   = w_accept && w_keep && (r_high_slot == 2'd3) && w_high_ok;
                w_high_wr.data = w_acc_next;
            end
            OP_FLUSH: begin
                w_high_wr.en = w_accept && w_high_ok;
            end
            default: begin
                w_high_wr.en = 1'b0;
            end
        endcase

        w_high_rd.en   = w_accept && (w_op == OP_READ) && (w_rd_kind == RD_HIGH);
        w_high_rd.addr = i_read_index[C_HIGH_AW-1:0];
        w_entry_rd_en  = w_accept && (w_op == OP_READ) && (w_rd_kind == RD_ENTRY);
    end

    satp_entry_ram u_entry_ram (
        .i_clk     (i_clk),
        .i_wr      (w_entry_wr),
        .i_rd_en   (w_entry_rd_en),
        .i_rd_addr (i_read_index[C_ENTRY_AW+1:2]),
        .o_rd_data (w_entry_data)
    );

    satp_high_ram u_high_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_high_wr),
        .i_rd      (w_high_rd),
        .o_rd_data (w_high_data)
    );

    // table state, updated at the accept edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_high_acc   <= '0;
            r_high_slot  <= '0;
            r_high_index <= '0;
            r_written    <= '0;
        end else if (w_accept) begin
            case (w_op)
                OP_ADD: begin
                    if (w_keep) begin
                        r_count                          <= r_count + 8'd1;
                        r_written[r_count[C_ENTRY_AW-1:0]] <= 1'b1;
                        if (r_high_slot == 2'd3) begin
                            r_high_acc   <= '0;
                            r_high_slot  <= '0;
                            r_high_index <= r_high_index + 6'd1;
                        end else begin
                            r_high_acc  <= w_acc_next;
                            r_high_slot <= r_high_slot + 2'd1;
                        end
                    end
                end
                OP_CLEAR: begin
                    r_count      <= '0;
                    r_high_acc   <= '0;
                    r_high_slot  <= '0;
                    r_high_index <= '0;
                    r_written    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // request context carried to the result cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_kept   <= (w_op == OP_ADD) && w_keep;
            r_res_full   <= (w_op == OP_ADD) && w_full;
            r_rd_kind    <= (w_op == OP_READ) ? w_rd_kind : RD_NONE;
            r_rd_byte    <= i_read_index[1:0];
            r_rd_written <= r_written[i_read_index[C_ENTRY_AW+1:2]];
        end
    end

    always_comb begin
        case (r_rd_byte)
            2'd0:    w_entry_byte = w_entry_data[7:0];
            2'd1:    w_entry_byte = w_entry_data[15:8];
            2'd2:    w_entry_byte = w_entry_data[23:16];
            default: w_entry_byte = w_entry_data[31:24];
        endcase
    end

    // unwritten entries show a hidden y, other bytes of them read as zero
    always_comb begin
        case (r_rd_kind)
            RD_ENTRY: begin
                if (r_rd_written) begin
                    w_res_data = w_entry_byte;
                end else begin
                    w_res_data = (r_rd_byte == 2'd1) ? C_HIDDEN_Y : 8'd0;
                end
            end
            RD_HIGH: w_res_data = w_high_data;
            default: w_res_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out_data <= w_res_data;
            r_out_kept <= r_res_kept;
            r_out_full <= r_res_full;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_sprite_kept = r_out_kept;
    assign o_table_full  = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 8'(C_MAX_SPRITES))
        else $error("sprite count beyond table size");

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!w_accept ##1 o_out_valid))
        else $error("result not presented after request");

    a_kept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_sprite_kept && o_table_full))
        else $error("add both kept and dropped");

    a_add_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_sprite_kept || o_table_full)) |-> (o_read_data == 8'd0))
        else $error("add result carries read data");

endmodule

`default_nettype wire

// ===== hdl/satp_entry_ram.sv =====
`default_nettype none

module satp_entry_ram import satp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire t_entry_wr             i_wr,
    input  wire logic                  i_rd_en,
    input  wire logic [C_ENTRY_AW-1:0] i_rd_addr,
    output logic [31:0]                o_rd_data
);

    // one word per sprite entry, byte 0 in the low bits
    logic [31:0] r_mem [C_ENTRY_COUNT];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/satp_high_ram.sv =====
`default_nettype none

module satp_high_ram import satp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_high_wr i_wr,
    input  wire t_high_rd i_rd,
    output logic [7:0]    o_rd_data
);

    logic [7:0]              r_mem [C_HIGH_BYTES];
    logic [C_HIGH_BYTES-1:0] r_valid;
    logic [7:0]              r_rd_data;

    // bytes never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_valid[i_rd.addr] ? r_mem[i_rd.addr] : 8'd0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== dv/sprite_table_checker.sv =====
`timescale 1ns / 100ps

module sprite_table_checker import satp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [15:0] i_sprite_x,
    input  wire logic signed [15:0] i_sprite_y,
    input  wire logic [8:0]         i_tile_id,
    input  wire logic [7:0]         i_attr_flags,
    input  wire logic [9:0]         i_read_index,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [7:0]         i_read_data,
    input  wire logic               i_sprite_kept,
    input  wire logic               i_table_full,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int C_ENTRY_BYTES = C_ENTRY_COUNT * 4;

    typedef struct packed {
        logic [7:0] data;
        logic       kept;
        logic       full;
    } t_table_reply;

    t_table_reply reply_queue[$];

    logic [7:0] shadow_entry   [C_ENTRY_BYTES];
    logic [7:0] shadow_high    [C_HIGH_BYTES];
    logic       shadow_written [C_ENTRY_COUNT];
    logic [7:0] shadow_acc;
    logic [1:0] shadow_slot;
    logic [5:0] shadow_hidx;
    logic [7:0] shadow_count;
    int         mismatches = 0;

    assign o_fail_count = mismatches;
    initial o_pending = 0;

    task automatic report_mismatch(string msg);
        if (mismatches < 200) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic empty_table();
        foreach (shadow_written[i]) begin
            shadow_written[i] = 1'b0;
        end
        shadow_acc   = '0;
        shadow_slot  = '0;
        shadow_hidx  = '0;
        shadow_count = '0;
    endtask

    function automatic logic [7:0] table_byte(logic [9:0] idx);
        if (idx >= C_TABLE_BYTES) begin
            return '0;
        end
        if (idx >= C_ENTRY_BYTES) begin
            return shadow_high[idx - C_ENTRY_BYTES];
        end
        if (shadow_written[idx >> 2]) begin
            return shadow_entry[idx];
        end
        // an empty entry shows only its y byte, parked below the screen
        return (idx[1:0] == 2'd1) ? C_HIDDEN_Y : 8'd0;
    endfunction

    task automatic apply_request();
        t_table_reply reply;
        logic         on_screen;
        int           base;
        reply = '0;
        case (t_op'(i_op))
            OP_ADD: begin
                on_screen = i_sprite_x > C_POS_MIN && i_sprite_x < C_X_LIMIT &&
                            i_sprite_y > C_POS_MIN && i_sprite_y < C_Y_LIMIT;
                if (on_screen && shadow_count >= C_MAX_SPRITES) begin
                    reply.full = 1'b1;
                end else if (on_screen && shadow_count < C_ENTRY_COUNT) begin
                    // two high bits per sprite: x bit8 low, size select high
                    shadow_acc = shadow_acc |
                                 (8'({i_attr_flags[0], i_sprite_x[8]}) << (2 * shadow_slot));
                    if (shadow_slot == 2'd3) begin
                        if (shadow_hidx < C_HIGH_BYTES) begin
                            shadow_high[shadow_hidx[4:0]] = shadow_acc;
                        end
                        shadow_hidx = shadow_hidx + 6'd1;
                        shadow_acc  = '0;
                        shadow_slot = '0;
                    end else begin
                        shadow_slot = shadow_slot + 2'd1;
                    end
                    base = int'(shadow_count) * 4;
                    shadow_entry[base]     = i_sprite_x[7:0];
                    shadow_entry[base + 1] = i_sprite_y[7:0];
                    shadow_entry[base + 2] = i_tile_id[7:0];
                    shadow_entry[base + 3] = {i_attr_flags[7:1], i_tile_id[8]};
                    shadow_written[shadow_count[6:0]] = 1'b1;
                    shadow_count = shadow_count + 8'd1;
                    reply.kept = 1'b1;
                end
            end
            OP_FLUSH: begin
                if (shadow_hidx < C_HIGH_BYTES) begin
                    shadow_high[shadow_hidx[4:0]] = shadow_acc;
                end
            end
            OP_READ: begin
                reply.data = table_byte(i_read_index);
            end
            default: begin
                empty_table();
            end
        endcase
        reply_queue.push_back(reply);
    endtask

    task automatic check_reply();
        t_table_reply want;
        if (reply_queue.size() == 0) begin
            report_mismatch($sformatf("reply with no request outstanding (data %0d)",
                                      i_read_data));
            return;
        end
        want = reply_queue.pop_front();
        if (i_read_data !== want.data) begin
            report_mismatch($sformatf("read_data got %0d, expected %0d",
                                      i_read_data, want.data));
        end
        if (i_sprite_kept !== want.kept) begin
            report_mismatch($sformatf("sprite_kept got %0b, expected %0b",
                                      i_sprite_kept, want.kept));
        end
        if (i_table_full !== want.full) begin
            report_mismatch($sformatf("table_full got %0b, expected %0b",
                                      i_table_full, want.full));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_high[i]) begin
                shadow_high[i] = '0;
            end
            empty_table();
            reply_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_reply();
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request();
            end
        end
        o_pending <= reply_queue.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import satp_pkg::*;

    localparam int C_REQUESTS    = 700;
    localparam int C_IDLE_LIMIT  = 4000;
    localparam int C_ENTRY_BYTES = C_ENTRY_COUNT * 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_op;
    logic signed [15:0] i_sprite_x;
    logic signed [15:0] i_sprite_y;
    logic [8:0]         i_tile_id;
    logic [7:0]         i_attr_flags;
    logic [9:0]         i_read_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [7:0]         o_read_data;
    logic               o_sprite_kept;
    logic               o_table_full;

    int fail_count;
    int pending;
    int stored_sprites = 0;
    int requests_sent  = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    always #10 i_clk = ~i_clk;

    sprite_attribute_table_packer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_sprite_x   (i_sprite_x),
        .i_sprite_y   (i_sprite_y),
        .i_tile_id    (i_tile_id),
        .i_attr_flags (i_attr_flags),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_sprite_kept(o_sprite_kept),
        .o_table_full (o_table_full)
    );

    sprite_table_checker u_table_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_sprite_x   (i_sprite_x),
        .i_sprite_y   (i_sprite_y),
        .i_tile_id    (i_tile_id),
        .i_attr_flags (i_attr_flags),
        .i_read_index (i_read_index),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_data  (o_read_data),
        .i_sprite_kept(o_sprite_kept),
        .i_table_full (o_table_full),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic bit in_window(logic signed [15:0] x, logic signed [15:0] y);
        return x > C_POS_MIN && x < C_X_LIMIT && y > C_POS_MIN && y < C_Y_LIMIT;
    endfunction

    // drives one request and holds it until taken; keeps a count of stored sprites
    // so that reads of an entry that was never written land only on its y byte
    task automatic offer(t_op op, logic signed [15:0] x, logic signed [15:0] y,
                         logic [8:0] tile, logic [7:0] flags, logic [9:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_sprite_x   <= x;
        i_sprite_y   <= y;
        i_tile_id    <= tile;
        i_attr_flags <= flags;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        requests_sent++;
        if (op == OP_ADD && in_window(x, y) && stored_sprites < C_MAX_SPRITES) begin
            stored_sprites++;
        end else if (op == OP_CLEAR) begin
            stored_sprites = 0;
        end
    endtask

    task automatic offer_plain(t_op op);
        offer(op, 16'($urandom), 16'($urandom), 9'($urandom), 8'($urandom), 10'($urandom));
    endtask

    task automatic offer_read(logic [9:0] idx);
        offer(OP_READ, 16'($urandom), 16'($urandom), 9'($urandom), 8'($urandom), idx);
    endtask

    task automatic offer_window_add();
        offer(OP_ADD, 16'($urandom_range(0, 318) - 63), 16'($urandom_range(0, 286) - 63),
              9'($urandom), 8'($urandom), 10'($urandom));
    endtask

    task automatic offer_stray_add();
        logic signed [15:0] x;
        logic signed [15:0] y;
        x = 16'($urandom_range(0, 318) - 63);
        y = 16'($urandom_range(0, 286) - 63);
        case ($urandom_range(0, 3))
            0: x = 16'($urandom);
            1: y = 16'($urandom);
            2: x = $urandom_range(0, 1) ? C_POS_MIN : C_X_LIMIT;
            default: y = $urandom_range(0, 1) ? C_POS_MIN : C_Y_LIMIT;
        endcase
        if (in_window(x, y)) begin
            x = C_X_LIMIT;
        end
        offer(OP_ADD, x, y, 9'($urandom), 8'($urandom), 10'($urandom));
    endtask

    function automatic logic [9:0] legal_read_index();
        case ($urandom_range(0, 3))
            0: begin
                if (stored_sprites > 0) begin
                    return 10'($urandom_range(0, stored_sprites * 4 - 1));
                end
            end
            1: begin
                // y byte of an empty entry
                if (stored_sprites < C_ENTRY_COUNT) begin
                    return 10'($urandom_range(stored_sprites, C_ENTRY_COUNT - 1) * 4 + 1);
                end
            end
            2: return 10'($urandom_range(C_ENTRY_BYTES, C_TABLE_BYTES - 1));
            default: return 10'($urandom_range(C_TABLE_BYTES, 1023));
        endcase
        return 10'($urandom_range(C_ENTRY_BYTES, C_TABLE_BYTES - 1));
    endfunction

    // receiver: runs of random stall density, one long hold-off to back the block up
    initial begin
        int  run_len;
        int  stall_pct;
        int  cycles;
        bit  held_off;
        i_out_stall = 1'b0;
        cycles      = 0;
        held_off    = 1'b0;
        forever begin
            run_len = $urandom_range(5, 60);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            if (!held_off && cycles > 300) begin
                held_off  = 1'b1;
                stall_pct = 100;
                run_len   = 250;
            end
            repeat (run_len) begin
                @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
                cycles++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("[sprite_attribute_table_packer_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int target;
        int adds;
        int episode;
        int pick;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_ADD;
        i_sprite_x   = '0;
        i_sprite_y   = '0;
        i_tile_id    = '0;
        i_attr_flags = '0;
        i_read_index = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, high table after reset, reads past the end
        offer_read(10'd1);
        offer_read(10'(C_ENTRY_BYTES));
        offer_read(10'd1023);
        offer_read(10'(C_TABLE_BYTES));
        // window corners and the positions just outside
        offer(OP_ADD, -16'sd63, -16'sd63, 9'h1FF, 8'hFF, 10'h3FF);
        offer(OP_ADD, -16'sd64, 16'sd0, 9'h0, 8'h0, 10'h0);
        offer(OP_ADD, 16'sd256, 16'sd0, 9'h0, 8'h0, 10'h0);
        offer(OP_ADD, 16'sd0, -16'sd64, 9'h0, 8'h0, 10'h0);
        offer(OP_ADD, 16'sd0, 16'sd224, 9'h0, 8'h0, 10'h0);
        offer(OP_ADD, -16'sd32768, 16'sd32767, 9'h1FF, 8'hFF, 10'h3FF);
        offer(OP_ADD, 16'sd255, 16'sd223, 9'h000, 8'h00, 10'h0);
        offer(OP_ADD, 16'sd0, 16'sd0, 9'h100, 8'h01, 10'h0);
        // partial high byte, then the fourth sprite completes it
        offer_plain(OP_FLUSH);
        offer(OP_ADD, 16'sd100, 16'sd100, 9'h0AA, 8'h55, 10'h0);
        offer_read(10'd0);
        offer_read(10'd1);
        offer_read(10'd2);
        offer_read(10'd3);
        offer_read(10'd7);
        offer_read(10'(C_ENTRY_BYTES));
        offer_read(10'(C_ENTRY_BYTES + 1));
        // clear keeps the high table
        offer_plain(OP_CLEAR);
        offer_read(10'd1);
        offer_read(10'(C_ENTRY_BYTES));

        episode = 0;
        while (requests_sent < C_REQUESTS) begin
            if (episode == 0 || $urandom_range(0, 4) != 0) begin
                offer_plain(OP_CLEAR);
            end
            // the first episode always runs past a full table
            target = (episode == 0 || $urandom_range(0, 2) == 0) ?
                     C_MAX_SPRITES + 12 : $urandom_range(1, 24);
            adds = 0;
            while (adds < target && requests_sent < C_REQUESTS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    offer_window_add();
                    adds++;
                end else if (pick < 78) begin
                    offer_stray_add();
                end else if (pick < 92) begin
                    offer_read(legal_read_index());
                end else begin
                    offer_plain(OP_FLUSH);
                end
            end
            offer_plain(OP_FLUSH);
            repeat ($urandom_range(3, 10)) offer_read(legal_read_index());
            episode++;
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[sprite_attribute_table_packer_top] OK");
        end else begin
            $display("[sprite_attribute_table_packer_top] ERROR");
        end
        $finish;
    end

endmodule
